### hdl/gmbr_pkg.sv
// shared constants, types and codes of the grid map bilinear remap core
`default_nettype none
package gmbr_pkg;

    localparam int GRID_STEP_DEF = 30;
    localparam int MAP_COLS_DEF  = 102;
    localparam int MAP_ROWS_DEF  = 68;

    localparam int COORD_W   = 20;
    localparam int ENTRY_W   = 2 * COORD_W;
    localparam int GRID_IDX_W = 7;
    localparam int OUT_X_W   = 12;
    localparam int OUT_Y_W   = 11;
    localparam int CFG_W     = 12;
    localparam int FRAC_BITS = 6;

    localparam logic [OUT_X_W-1:0] SRC_WIDTH_RST  = 12'd3000;
    localparam logic [OUT_Y_W-1:0] SRC_HEIGHT_RST = 11'd2000;

    typedef enum logic [1:0] {
        ST_MAPPED    = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_WRITTEN   = 2'd2
    } t_status;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_MAP   = 1'b1
    } t_func;

    typedef enum logic {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic       en;
        logic [1:0] bank;
    } t_mem_wr_ctl;

endpackage
`default_nettype wire

### hdl/gmbr_ifs.sv
// valid/ready channel interfaces for input items and results
`default_nettype none
interface gmbr_in_if;
    import gmbr_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [GRID_IDX_W-1:0]        grid_col;
    logic [GRID_IDX_W-1:0]        grid_row;
    logic signed [COORD_W-1:0]    entry_src_x;
    logic signed [COORD_W-1:0]    entry_src_y;
    logic                         last_entry;
    logic [OUT_X_W-1:0]           out_x;
    logic [OUT_Y_W-1:0]           out_y;

    modport source (output valid, func, grid_col, grid_row, entry_src_x, entry_src_y,
                    last_entry, out_x, out_y, input ready);
    modport sink (input valid, func, grid_col, grid_row, entry_src_x, entry_src_y,
                  last_entry, out_x, out_y, output ready);
endinterface

interface gmbr_out_if;
    import gmbr_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               inside_res;
    logic [OUT_X_W-1:0] src_col;
    logic [OUT_Y_W-1:0] src_row;

    modport source (output valid, status, inside_res, src_col, src_row, input ready);
    modport sink (input valid, status, inside_res, src_col, src_row, output ready);
endinterface
`default_nettype wire

### hdl/gmbr_grid_mem.sv
// four parity banks of grid entries, one write and four reads per cycle while i_en is high
`default_nettype none
module gmbr_grid_mem #(
    parameter int DEPTH = 1,
    parameter int AW    = 1
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  gmbr_pkg::t_mem_wr_ctl        i_wr,
    input  wire [AW-1:0]                 i_waddr,
    input  wire [gmbr_pkg::ENTRY_W-1:0]  i_wdata,
    input  wire [AW-1:0]                 i_raddr [4],
    output logic [gmbr_pkg::ENTRY_W-1:0] o_rdata [4]
);
    import gmbr_pkg::*;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [ENTRY_W-1:0] r_mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_en && i_wr.en && (i_wr.bank == 2'(b))) begin
                r_mem[i_waddr] <= i_wdata;
            end
            if (i_en) begin
                o_rdata[b] <= r_mem[i_raddr[b]];
            end
        end
    end
endmodule
`default_nettype wire

### hdl/grid_map_bilinear_remap_core.sv
// top level: grid map storage, bilinear interpolation and bounds check
//
// channels: i_in takes items (func 0 writes one grid entry, func 1 maps one
// output pixel); o_out returns exactly one result per item, in order.
// configuration: i_cfg_we writes source_width (index 0) or source_height
// (index 1) from i_cfg_data; write only while no transaction is in flight.
// throughput: one item per cycle while o_out is not stalled; the four grid corners come from four
// parity banks read in the same cycle, so any pixel order sustains the rate.
// an item passes the stage registers a to h in order; its result leaves from the output register.
// the whole pipeline moves together; when the receiver stalls the output
// register holds and i_in.ready drops in the same cycle.
// reset: map not ready, source size 3000 x 2000; grid entries keep no reset
// and must be written before a pixel reads them.
`default_nettype none
module grid_map_bilinear_remap_core #(
    parameter int GRID_STEP = gmbr_pkg::GRID_STEP_DEF,
    parameter int MAP_COLS  = gmbr_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS  = gmbr_pkg::MAP_ROWS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_idx,
    input  wire [gmbr_pkg::CFG_W-1:0]  i_cfg_data,
    gmbr_in_if.sink                    i_in,
    gmbr_out_if.source                 o_out
);
    import gmbr_pkg::*;

    localparam int WW    = $clog2(GRID_STEP + 1);
    localparam int CXW   = $clog2(MAP_COLS);
    localparam int CYW   = $clog2(MAP_ROWS);
    localparam int HC    = (MAP_COLS + 1) / 2;
    localparam int HR    = (MAP_ROWS + 1) / 2;
    localparam int DEPTH = HC * HR;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIMX  = (MAP_COLS - 1) * GRID_STEP;
    localparam int LIMY  = (MAP_ROWS - 1) * GRID_STEP;
    localparam int K1    = OUT_X_W + 1;
    localparam int R1    = (2 ** K1) / GRID_STEP;
    localparam int R1W   = K1 + 1;
    localparam int LFW   = COORD_W + WW + 1;
    localparam int NW    = LFW + WW + 1;
    localparam int D2    = GRID_STEP * GRID_STEP;
    localparam int DEN   = 64 * D2;
    localparam int DENW  = $clog2(DEN + 1);
    localparam int HALF  = DEN / 2;
    localparam int LMW   = OUT_X_W + DENW;
    localparam int CW    = (NW > LMW ? NW : LMW) + 1;
    localparam int VW    = OUT_X_W + 2 * WW;
    localparam int K2    = VW + 1;
    localparam int R2    = (2 ** K2) / D2;
    localparam int R2W   = K2 + 1;

    logic                 w_en;
    logic                 w_acc;
    logic [OUT_X_W-1:0]   r_src_w;
    logic [OUT_Y_W-1:0]   r_src_h;
    logic                 r_map_ready;

    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;
    assign w_acc      = i_in.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= SRC_WIDTH_RST;
            r_src_h     <= SRC_HEIGHT_RST;
            r_map_ready <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    REG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                    REG_SRC_HEIGHT: r_src_h <= i_cfg_data[OUT_Y_W-1:0];
                    default:        r_src_w <= r_src_w;
                endcase
            end
            if (w_acc && (t_func'(i_in.func) == FUNC_WRITE) && i_in.last_entry) begin
                r_map_ready <= 1'b1;
            end
        end
    end

    // stage a: clamp and reciprocal multiply
    logic [OUT_X_W-1:0]       w_px;
    logic [OUT_X_W-1:0]       w_py;
    logic [OUT_X_W+R1W-1:0]   w_prx;
    logic [OUT_X_W+R1W-1:0]   w_pry;
    logic                     r_a_v;
    t_status                  r_a_k;
    logic [OUT_X_W-1:0]       r_a_px;
    logic [OUT_X_W-1:0]       r_a_py;
    logic [OUT_X_W-1:0]       r_a_qx;
    logic [OUT_X_W-1:0]       r_a_qy;
    logic                     r_a_we;
    logic [GRID_IDX_W-1:0]    r_a_col;
    logic [GRID_IDX_W-1:0]    r_a_row;
    logic [ENTRY_W-1:0]       r_a_data;

    always_comb begin
        w_px = (32'(i_in.out_x) > LIMX) ? OUT_X_W'(LIMX) : i_in.out_x;
        w_py = (32'(i_in.out_y) > LIMY) ? OUT_X_W'(LIMY) : OUT_X_W'(i_in.out_y);
        w_prx = (OUT_X_W+R1W)'(w_px) * (OUT_X_W+R1W)'(R1);
        w_pry = (OUT_X_W+R1W)'(w_py) * (OUT_X_W+R1W)'(R1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in.valid;
        end
        if (w_en) begin
            if (t_func'(i_in.func) == FUNC_WRITE) begin
                r_a_k <= ST_WRITTEN;
            end else if (!r_map_ready) begin
                r_a_k <= ST_NOT_READY;
            end else begin
                r_a_k <= ST_MAPPED;
            end
            r_a_px   <= w_px;
            r_a_py   <= w_py;
            r_a_qx   <= w_prx[K1+OUT_X_W-1:K1];
            r_a_qy   <= w_pry[K1+OUT_X_W-1:K1];
            r_a_we   <= (t_func'(i_in.func) == FUNC_WRITE)
                        && (32'(i_in.grid_col) < MAP_COLS) && (32'(i_in.grid_row) < MAP_ROWS);
            r_a_col  <= i_in.grid_col;
            r_a_row  <= i_in.grid_row;
            r_a_data <= {i_in.entry_src_x, i_in.entry_src_y};
        end
    end

    // stage b: quotient correction and edge clamp
    logic [OUT_X_W-1:0]   w_qx;
    logic [OUT_X_W-1:0]   w_qy;
    logic [OUT_X_W-1:0]   w_rx;
    logic [OUT_X_W-1:0]   w_ry;
    logic [OUT_X_W-1:0]   w_cx;
    logic [OUT_X_W-1:0]   w_cy;
    logic [WW-1:0]        w_fx;
    logic [WW-1:0]        w_fy;
    logic                 r_b_v;
    t_status              r_b_k;
    logic [CXW-1:0]       r_b_cx;
    logic [CYW-1:0]       r_b_cy;
    logic [WW-1:0]        r_b_fx;
    logic [WW-1:0]        r_b_fy;
    t_mem_wr_ctl          r_b_wr;
    logic [AW-1:0]        r_b_waddr;
    logic [ENTRY_W-1:0]   r_b_data;

    always_comb begin
        w_rx = r_a_px - OUT_X_W'(r_a_qx * OUT_X_W'(GRID_STEP));
        w_ry = r_a_py - OUT_X_W'(r_a_qy * OUT_X_W'(GRID_STEP));
        w_qx = r_a_qx;
        w_qy = r_a_qy;
        if (32'(w_rx) >= GRID_STEP) begin
            w_qx = r_a_qx + 1'b1;
            w_rx = w_rx - OUT_X_W'(GRID_STEP);
        end
        if (32'(w_ry) >= GRID_STEP) begin
            w_qy = r_a_qy + 1'b1;
            w_ry = w_ry - OUT_X_W'(GRID_STEP);
        end
        w_cx = w_qx;
        w_fx = w_rx[WW-1:0];
        if (32'(w_qx) >= MAP_COLS - 1) begin
            w_cx = OUT_X_W'(MAP_COLS - 2);
            w_fx = WW'(GRID_STEP);
        end
        w_cy = w_qy;
        w_fy = w_ry[WW-1:0];
        if (32'(w_qy) >= MAP_ROWS - 1) begin
            w_cy = OUT_X_W'(MAP_ROWS - 2);
            w_fy = WW'(GRID_STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
        if (w_en) begin
            r_b_k        <= r_a_k;
            r_b_cx       <= w_cx[CXW-1:0];
            r_b_cy       <= w_cy[CYW-1:0];
            r_b_fx       <= w_fx;
            r_b_fy       <= w_fy;
            r_b_wr.en    <= r_a_v && r_a_we;
            r_b_wr.bank  <= {r_a_row[0], r_a_col[0]};
            r_b_waddr    <= AW'(32'(r_a_row[GRID_IDX_W-1:1]) * HC
                                + 32'(r_a_col[GRID_IDX_W-1:1]));
            r_b_data     <= r_a_data;
        end
    end

    // stage c: bank addresses, memory access
    logic [AW-1:0]        w_raddr [4];
    logic [ENTRY_W-1:0]   w_rdata [4];
    logic                 r_c_v;
    t_status              r_c_k;
    logic                 r_c_cx0;
    logic                 r_c_cy0;
    logic [WW-1:0]        r_c_fx;
    logic [WW-1:0]        r_c_fy;

    always_comb begin
        logic [CYW-1:0] rsel;
        logic [CXW-1:0] csel;
        rsel = '0;
        csel = '0;
        for (int b = 0; b < 4; b++) begin
            rsel = r_b_cy + CYW'(r_b_cy[0] != b[1]);
            csel = r_b_cx + CXW'(r_b_cx[0] != b[0]);
            w_raddr[b] = AW'(32'(rsel[CYW-1:1]) * HC + 32'(csel[CXW-1:1]));
        end
    end

    gmbr_grid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_wr    (r_b_wr),
        .i_waddr (r_b_waddr),
        .i_wdata (r_b_data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_b_v;
        end
        if (w_en) begin
            r_c_k   <= r_b_k;
            r_c_cx0 <= r_b_cx[0];
            r_c_cy0 <= r_b_cy[0];
            r_c_fx  <= r_b_fx;
            r_c_fy  <= r_b_fy;
        end
    end

    // stage d: vertical blend of left and right columns
    logic signed [COORD_W-1:0] w_ex [4];
    logic signed [COORD_W-1:0] w_ey [4];
    logic signed [WW:0]        w_wy1;
    logic signed [WW:0]        w_wy0;
    logic                      r_d_v;
    t_status                   r_d_k;
    logic [WW-1:0]             r_d_fx;
    logic signed [LFW-1:0]     r_d_lx;
    logic signed [LFW-1:0]     r_d_rx;
    logic signed [LFW-1:0]     r_d_ly;
    logic signed [LFW-1:0]     r_d_ry;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            w_ex[b] = w_rdata[{r_c_cy0 ^ b[1], r_c_cx0 ^ b[0]}][ENTRY_W-1:COORD_W];
            w_ey[b] = w_rdata[{r_c_cy0 ^ b[1], r_c_cx0 ^ b[0]}][COORD_W-1:0];
        end
        w_wy1 = $signed({1'b0, r_c_fy});
        w_wy0 = $signed({1'b0, WW'(GRID_STEP) - r_c_fy});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_d_v <= r_c_v;
        end
        if (w_en) begin
            r_d_k  <= r_c_k;
            r_d_fx <= r_c_fx;
            r_d_lx <= LFW'(w_ex[0] * w_wy0) + LFW'(w_ex[2] * w_wy1);
            r_d_rx <= LFW'(w_ex[1] * w_wy0) + LFW'(w_ex[3] * w_wy1);
            r_d_ly <= LFW'(w_ey[0] * w_wy0) + LFW'(w_ey[2] * w_wy1);
            r_d_ry <= LFW'(w_ey[1] * w_wy0) + LFW'(w_ey[3] * w_wy1);
        end
    end

    // stage e: horizontal blend
    logic signed [WW:0]    w_wx1;
    logic signed [WW:0]    w_wx0;
    logic                  r_e_v;
    t_status               r_e_k;
    logic signed [NW-1:0]  r_e_nx;
    logic signed [NW-1:0]  r_e_ny;

    assign w_wx1 = $signed({1'b0, r_d_fx});
    assign w_wx0 = $signed({1'b0, WW'(GRID_STEP) - r_d_fx});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= r_d_v;
        end
        if (w_en) begin
            r_e_k  <= r_d_k;
            r_e_nx <= NW'(r_d_lx * w_wx0) + NW'(r_d_rx * w_wx1);
            r_e_ny <= NW'(r_d_ly * w_wx0) + NW'(r_d_ry * w_wx1);
        end
    end

    // stage f: bounds check and scale to 1/(S*S)
    logic [LMW-1:0]   w_limx;
    logic [LMW-1:0]   w_limy;
    logic             w_inx;
    logic             w_iny;
    logic [NW:0]      w_sx;
    logic [NW:0]      w_sy;
    logic             r_f_v;
    t_status          r_f_k;
    logic             r_f_in;
    logic [VW-1:0]    r_f_vx;
    logic [VW-1:0]    r_f_vy;

    always_comb begin
        w_limx = LMW'(r_src_w - 1'b1) * LMW'(DEN);
        w_limy = LMW'(r_src_h - 1'b1) * LMW'(DEN);
        w_inx  = (r_src_w != '0) && !r_e_nx[NW-1]
                 && (CW'(unsigned'(r_e_nx)) <= CW'(w_limx));
        w_iny  = (r_src_h != '0) && !r_e_ny[NW-1]
                 && (CW'(unsigned'(r_e_ny)) <= CW'(w_limy));
        w_sx   = (NW+1)'(unsigned'(r_e_nx)) + (NW+1)'(HALF);
        w_sy   = (NW+1)'(unsigned'(r_e_ny)) + (NW+1)'(HALF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= r_e_v;
        end
        if (w_en) begin
            r_f_k  <= r_e_k;
            r_f_in <= w_inx && w_iny;
            r_f_vx <= w_sx[VW+FRAC_BITS-1:FRAC_BITS];
            r_f_vy <= w_sy[VW+FRAC_BITS-1:FRAC_BITS];
        end
    end

    // stage g: reciprocal multiply by 1/(S*S)
    logic [VW+R2W-1:0]  w_pvx;
    logic [VW+R2W-1:0]  w_pvy;
    logic               r_g_v;
    t_status            r_g_k;
    logic               r_g_in;
    logic [VW-1:0]      r_g_vx;
    logic [VW-1:0]      r_g_vy;
    logic [OUT_X_W-1:0] r_g_qx;
    logic [OUT_X_W-1:0] r_g_qy;

    assign w_pvx = (VW+R2W)'(r_f_vx) * (VW+R2W)'(R2);
    assign w_pvy = (VW+R2W)'(r_f_vy) * (VW+R2W)'(R2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_g_v <= r_f_v;
        end
        if (w_en) begin
            r_g_k  <= r_f_k;
            r_g_in <= r_f_in;
            r_g_vx <= r_f_vx;
            r_g_vy <= r_f_vy;
            r_g_qx <= w_pvx[K2+OUT_X_W-1:K2];
            r_g_qy <= w_pvy[K2+OUT_X_W-1:K2];
        end
    end

    // stage h: quotient correction into the output register
    logic [VW-1:0]      w_remx;
    logic [VW-1:0]      w_remy;
    logic [OUT_X_W-1:0] w_colq;
    logic [OUT_X_W-1:0] w_rowq;
    logic               r_o_v;
    t_status            r_o_k;
    logic               r_o_in;
    logic [OUT_X_W-1:0] r_o_col;
    logic [OUT_Y_W-1:0] r_o_row;

    always_comb begin
        w_remx = r_g_vx - VW'(r_g_qx * VW'(D2));
        w_remy = r_g_vy - VW'(r_g_qy * VW'(D2));
        w_colq = r_g_qx + OUT_X_W'(w_remx >= VW'(D2));
        w_rowq = r_g_qy + OUT_X_W'(w_remy >= VW'(D2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= r_g_v;
        end
        if (w_en) begin
            r_o_k <= r_g_k;
            if ((r_g_k == ST_MAPPED) && r_g_in) begin
                r_o_in  <= 1'b1;
                r_o_col <= w_colq;
                r_o_row <= w_rowq[OUT_Y_W-1:0];
            end else begin
                r_o_in  <= 1'b0;
                r_o_col <= '0;
                r_o_row <= '0;
            end
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.status     = r_o_k;
    assign o_out.inside_res = r_o_in;
    assign o_out.src_col    = r_o_col;
    assign o_out.src_row    = r_o_row;

endmodule
`default_nettype wire
